[sv/ipr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_pkg
// types and constants shared by the image packet receiver modules
// ----------------------------------------------------------------------------
package ipr_pkg;

    localparam int MAX_DATA_BYTES = 256;
    localparam int BL_W           = $clog2(MAX_DATA_BYTES + 1);
    localparam logic [15:0] LEN_MIN = 16'd2;
    localparam logic [15:0] LEN_MAX = 16'(MAX_DATA_BYTES + 2);

    localparam logic [7:0] PIXEL_MASK = 8'hF0;
    localparam int         NIBBLE     = 4;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_PIXELS = 2'd0;
    localparam logic [1:0] REG_DATA_TYPE    = 2'd1;
    localparam logic [1:0] REG_END_TYPE     = 2'd2;

    localparam logic [15:0] IMAGE_PIXELS_RST = 16'd36864;
    localparam logic [7:0]  DATA_TYPE_RST    = 8'd2;
    localparam logic [7:0]  END_TYPE_RST     = 8'd8;

    // result kinds
    localparam logic KIND_PIXELS = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // packet status codes
    localparam logic [2:0] ST_MORE      = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
    localparam logic [2:0] ST_CHECKSUM  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_BAD_LEN   = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_first;
        logic [7:0] pixel_second;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        logic [15:0] image_pixels;
        logic [7:0]  data_type_code;
        logic [7:0]  end_type_code;
    } cfg_t;

endpackage

[sv/ipr_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_cfg_regs
// configuration registers: image size and the two packet type codes
// ----------------------------------------------------------------------------
module ipr_cfg_regs
    import ipr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_IMAGE_PIXELS: cfg_next.image_pixels   = wr_data;
                REG_DATA_TYPE:    cfg_next.data_type_code = wr_data[7:0];
                REG_END_TYPE:     cfg_next.end_type_code  = wr_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_pixels   <= IMAGE_PIXELS_RST;
            cfg_reg.data_type_code <= DATA_TYPE_RST;
            cfg_reg.end_type_code  <= END_TYPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/ipr_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_parser
// packet state and per-byte parse: header skip, type, length, data, checksum
// ----------------------------------------------------------------------------
module ipr_parser
    import ipr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output logic      res_valid,
    output out_item_t res_item
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_DATA,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_STOPPED
    } phase_t;

    typedef enum logic [1:0] {
        PK_DATA,
        PK_END,
        PK_OTHER
    } pkt_kind_t;

    phase_t          phase_reg,    phase_next;
    logic [3:0]      hdr_idx_reg,  hdr_idx_next;
    logic [15:0]     sum_reg,      sum_next;
    logic [7:0]      len_hi_reg,   len_hi_next;
    logic [BL_W-1:0] left_reg,     left_next;
    pkt_kind_t       pkind_reg,    pkind_next;
    logic [7:0]      sum_hi_reg,   sum_hi_next;
    logic [15:0]     pw_reg,       pw_next;
    logic            ovf_reg,      ovf_next;

    logic [7:0]  b;
    logic [15:0] len_full;
    logic [15:0] sum_add;
    logic        room_short;
    logic        emit;
    logic [2:0]  emit_code;

    assign b          = item.rx_byte;
    assign len_full   = {len_hi_reg, b};
    assign sum_add    = sum_reg + {8'd0, b};
    assign room_short = ({1'b0, pw_reg} + 17'd2) > {1'b0, cfg.image_pixels};

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        sum_next     = sum_reg;
        len_hi_next  = len_hi_reg;
        left_next    = left_reg;
        pkind_next   = pkind_reg;
        sum_hi_next  = sum_hi_reg;
        pw_next      = pw_reg;
        ovf_next     = ovf_reg;
        emit         = 1'b0;
        emit_code    = ST_MORE;
        res_valid    = 1'b0;
        res_item     = '0;

        if (fire)
        begin
            if (item.restart)
            begin
                phase_next   = PH_HEADER;
                hdr_idx_next = 4'd0;
                sum_next     = 16'd0;
                len_hi_next  = 8'd0;
                left_next    = '0;
                pkind_next   = PK_DATA;
                sum_hi_next  = 8'd0;
                pw_next      = 16'd0;
                ovf_next     = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (hdr_idx_reg < 4'd6)
                        begin
                            hdr_idx_next = hdr_idx_reg + 4'd1;
                        end
                        else if (hdr_idx_reg == 4'd6)
                        begin
                            if (b == cfg.data_type_code)
                                pkind_next = PK_DATA;
                            else if (b == cfg.end_type_code)
                                pkind_next = PK_END;
                            else
                                pkind_next = PK_OTHER;
                            sum_next     = {8'd0, b};
                            hdr_idx_next = 4'd7;
                        end
                        else if (hdr_idx_reg == 4'd7)
                        begin
                            len_hi_next  = b;
                            sum_next     = sum_add;
                            hdr_idx_next = 4'd8;
                        end
                        else
                        begin
                            sum_next     = sum_add;
                            hdr_idx_next = 4'd0;
                            if (pkind_reg == PK_OTHER)
                            begin
                                emit      = 1'b1;
                                emit_code = ST_WRONG_TYPE;
                            end
                            else if (len_full < LEN_MIN || len_full > LEN_MAX)
                            begin
                                emit      = 1'b1;
                                emit_code = ST_BAD_LEN;
                            end
                            else
                            begin
                                left_next  = BL_W'(len_full - LEN_MIN);
                                phase_next = (len_full == LEN_MIN) ? PH_SUM_HI : PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        sum_next  = sum_add;
                        left_next = left_reg - BL_W'(1);
                        if (left_reg == BL_W'(1))
                            phase_next = PH_SUM_HI;
                        if (pkind_reg == PK_DATA)
                        begin
                            if (ovf_reg || room_short)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                pw_next               = pw_reg + 16'd2;
                                res_valid             = 1'b1;
                                res_item.kind         = KIND_PIXELS;
                                res_item.pixel_first  = b & PIXEL_MASK;
                                res_item.pixel_second = b << NIBBLE;
                            end
                        end
                    end
                    PH_SUM_HI:
                    begin
                        sum_hi_next = b;
                        phase_next  = PH_SUM_LO;
                    end
                    PH_SUM_LO:
                    begin
                        emit = 1'b1;
                        if ({sum_hi_reg, b} != sum_reg)
                            emit_code = ST_CHECKSUM;
                        else if (ovf_reg)
                            emit_code = ST_OVERFLOW;
                        else if (pkind_reg == PK_END)
                            emit_code = ST_DONE;
                        else
                            emit_code = ST_MORE;
                    end
                    PH_STOPPED:
                    begin
                        phase_next = PH_STOPPED;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                if (emit)
                begin
                    phase_next      = (emit_code == ST_MORE) ? PH_HEADER : PH_STOPPED;
                    hdr_idx_next    = 4'd0;
                    res_valid       = 1'b1;
                    res_item.kind   = KIND_STATUS;
                    res_item.status = emit_code;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= 4'd0;
            sum_reg     <= 16'd0;
            len_hi_reg  <= 8'd0;
            left_reg    <= '0;
            pkind_reg   <= PK_DATA;
            sum_hi_reg  <= 8'd0;
            pw_reg      <= 16'd0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            sum_reg     <= sum_next;
            len_hi_reg  <= len_hi_next;
            left_reg    <= left_next;
            pkind_reg   <= pkind_next;
            sum_hi_reg  <= sum_hi_next;
            pw_reg      <= pw_next;
            ovf_reg     <= ovf_next;
        end
    end

    // stopped image stays stopped until restart
    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STOPPED && !(fire && item.restart)) |=> phase_reg == PH_STOPPED)
        else $error("stopped image left without restart");

    a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= 4'd8)
        else $error("header index out of range");

    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> left_reg != '0)
        else $error("data phase with no bytes left");

    a_pw_even: assert property (@(posedge clk) disable iff (!rst_n)
        pw_reg[0] == 1'b0)
        else $error("odd pixel count");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.restart) |=> (phase_reg == PH_HEADER && hdr_idx_reg == 4'd0 &&
                                     pw_reg == 16'd0 && !ovf_reg))
        else $error("restart did not clear state");

endmodule

[sv/ipr_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_out_buf
// two-entry result buffer, registered full flag back-pressures the input
// ----------------------------------------------------------------------------
module ipr_out_buf
    import ipr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_item
);

    out_item_t  ent0_reg, ent0_next;
    out_item_t  ent1_reg, ent1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] base;

    assign pop  = (count_reg != 2'd0) && !res_stall;
    assign base = pop ? (count_reg - 2'd1) : count_reg;

    always_comb
    begin
        ent0_next  = pop ? ent1_reg : ent0_reg;
        ent1_next  = ent1_reg;
        if (push && base == 2'd0)
            ent0_next = push_item;
        if (push && base == 2'd1)
            ent1_next = push_item;
        count_next = base + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign full      = (count_reg == 2'd2);
    assign res_valid = (count_reg != 2'd0);
    assign res_item  = ent0_reg;

endmodule

[sv/image_packet_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_packet_receiver
// parses received sensor image packets into pixel pairs and packet status
// ----------------------------------------------------------------------------
//  channel  signals                        direction  item
//  rx       rx_valid, rx_stall, rx_item    in         received byte, restart
//  res      res_valid, res_stall, res_item out        pixel pair or status
//  cfg      cfg_valid, cfg_ready,          in         register write
//           cfg_index, cfg_data
//
//  one byte is taken per cycle while rx_stall is low; its result, if any,
//  is registered; the parse is combinational between the packet state and
//  a two-entry result buffer; rx_stall rises only while it holds two results
//  cfg_ready is always high; reset restores the register defaults and needs
//  no clearing pass
// ----------------------------------------------------------------------------
module image_packet_receiver
    import ipr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  in_item_t    rx_item,
    output logic        res_valid,
    input  logic        res_stall,
    output out_item_t   res_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg;
    logic      fire;
    logic      full;
    logic      parse_valid;
    out_item_t parse_item;

    assign cfg_ready = 1'b1;
    assign rx_stall  = full;
    assign fire      = rx_valid && !full;

    ipr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ipr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (rx_item),
        .cfg       (cfg),
        .res_valid (parse_valid),
        .res_item  (parse_item)
    );

    ipr_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (parse_valid),
        .push_item (parse_item),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
